### src/lne_pkg.sv
package lne_pkg;

    localparam int NODE_COUNT  = 512;
    localparam int NODE_W      = 9;
    localparam int RESULT_BITS = 64;
    localparam int POS_W       = 6;

    localparam logic [1:0] ACT_GATE  = 2'd0;
    localparam logic [1:0] ACT_LEVEL = 2'd1;
    localparam logic [1:0] ACT_EVAL  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_GATE  = 2'd1;
    localparam logic [1:0] KIND_LEVEL = 2'd2;

    localparam logic [1:0] FN_AND = 2'd0;
    localparam logic [1:0] FN_OR  = 2'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node_index;
        logic [NODE_W-1:0] operand_a;
        logic [NODE_W-1:0] operand_b;
        logic [1:0]        gate_op;
        logic              wire_value;
        logic              is_output;
        logic [POS_W-1:0]  out_bit;
    } t_in;

    typedef struct packed {
        logic [RESULT_BITS-1:0] result_word;
        logic                   unresolved;
    } t_out;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        fn;
        logic [NODE_W-1:0] src_a;
        logic [NODE_W-1:0] src_b;
        logic              level;
        logic              omark;
        logic [POS_W-1:0]  opos;
    } t_def;

    typedef struct packed {
        logic known;
        logic level;
    } t_eval;

    localparam int DEF_W  = $bits(t_def);
    localparam int EVAL_W = $bits(t_eval);

    function automatic logic apply_gate(input logic [1:0] fn, input logic a, input logic b);
        logic r;
        unique case (fn)
            FN_AND:  r = a & b;
            FN_OR:   r = a | b;
            default: r = a ^ b;
        endcase
        return r;
    endfunction

endpackage

### src/lne_ram.sv
module lne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/logic_netlist_evaluator_core.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | i_valid / o_stall | i_data (t_in)
// out     | output    | o_valid / i_stall | o_data (t_out)
//
// Gate and level beats are written to the node table as they are accepted; a clear
// beat starts a sweep of the node table, one entry a cycle, as does reset.
// An evaluate beat seeds levels (read, then write each node), runs propagation
// passes (read, source fetch, calculate each node) that repeat until one resolves
// nothing, then gathers outputs; each pass is bound by the node-table read port.
// Input is stalled while a sweep or evaluation runs; a waiting result does not
// stall input until the next result is ready.
module logic_netlist_evaluator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lne_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output lne_pkg::t_out o_data
);
    import lne_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_INIT_RD = 4'd2;
    localparam logic [3:0] S_INIT_WR = 4'd3;
    localparam logic [3:0] S_P_RD    = 4'd4;
    localparam logic [3:0] S_P_SRC   = 4'd5;
    localparam logic [3:0] S_P_CALC  = 4'd6;
    localparam logic [3:0] S_O_RD    = 4'd7;
    localparam logic [3:0] S_O_ACC   = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]             r_state, n_state;
    logic [NODE_W-1:0]      r_idx, n_idx;
    logic                   r_changed, n_changed;
    logic                   r_own, n_own;
    logic [RESULT_BITS-1:0] r_word, n_word;
    logic                   r_flag, n_flag;
    logic                   r_ov, n_ov;
    t_out                   r_out, n_out;

    logic              def_we;
    logic [NODE_W-1:0] def_waddr;
    t_def              def_wdata, def_rd;
    logic              ev_we;
    t_eval             ev_wdata, ev_a, ev_b;
    logic [NODE_W-1:0] ev_a_raddr, ev_b_raddr;
    logic              last, accept, res;

    lne_ram #(.WIDTH(DEF_W), .DEPTH(NODE_COUNT)) u_def (
        .i_clk(i_clk), .i_we(def_we), .i_waddr(def_waddr), .i_wdata(def_wdata),
        .i_raddr(r_idx), .o_rdata(def_rd)
    );
    lne_ram #(.WIDTH(EVAL_W), .DEPTH(NODE_COUNT)) u_eva (
        .i_clk(i_clk), .i_we(ev_we), .i_waddr(r_idx), .i_wdata(ev_wdata),
        .i_raddr(ev_a_raddr), .o_rdata(ev_a)
    );
    lne_ram #(.WIDTH(EVAL_W), .DEPTH(NODE_COUNT)) u_evb (
        .i_clk(i_clk), .i_we(ev_we), .i_waddr(r_idx), .i_wdata(ev_wdata),
        .i_raddr(ev_b_raddr), .o_rdata(ev_b)
    );

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign last    = (r_idx == NODE_W'(NODE_COUNT - 1));
    assign res     = (def_rd.kind == KIND_GATE) && !r_own && ev_a.known && ev_b.known;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_changed  = r_changed;
        n_own      = r_own;
        n_word     = r_word;
        n_flag     = r_flag;
        n_ov       = r_ov && i_stall;
        n_out      = r_out;
        def_we     = 1'b0;
        def_waddr  = r_idx;
        def_wdata  = '0;
        ev_we      = 1'b0;
        ev_wdata   = '0;
        ev_a_raddr = r_idx;
        ev_b_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_data.action)
                        ACT_GATE, ACT_LEVEL: begin
                            def_we          = 1'b1;
                            def_waddr       = i_data.node_index;
                            def_wdata.kind  = (i_data.action == ACT_GATE) ? KIND_GATE
                                                                           : KIND_LEVEL;
                            def_wdata.fn    = i_data.gate_op;
                            def_wdata.src_a = i_data.operand_a;
                            def_wdata.src_b = i_data.operand_b;
                            def_wdata.level = i_data.wire_value;
                            def_wdata.omark = i_data.is_output;
                            def_wdata.opos  = i_data.out_bit;
                        end
                        ACT_EVAL: begin
                            n_idx   = '0;
                            n_state = S_INIT_RD;
                        end
                        default: begin
                            n_idx   = '0;
                            n_state = S_CLR;
                        end
                    endcase
                end
            end
            S_CLR: begin
                def_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            S_INIT_RD: n_state = S_INIT_WR;
            S_INIT_WR: begin
                ev_we          = 1'b1;
                ev_wdata.known = (def_rd.kind == KIND_LEVEL);
                ev_wdata.level = (def_rd.kind == KIND_LEVEL) && def_rd.level;
                n_idx          = r_idx + 1'b1;
                if (last) begin
                    n_changed = 1'b0;
                    n_state   = S_P_RD;
                end else begin
                    n_state = S_INIT_RD;
                end
            end
            S_P_RD: n_state = S_P_SRC;
            S_P_SRC: begin
                n_own      = ev_a.known;
                ev_a_raddr = def_rd.src_a;
                ev_b_raddr = def_rd.src_b;
                n_state    = S_P_CALC;
            end
            S_P_CALC: begin
                ev_a_raddr = def_rd.src_a;
                ev_b_raddr = def_rd.src_b;
                if (res) begin
                    ev_we          = 1'b1;
                    ev_wdata.known = 1'b1;
                    ev_wdata.level = apply_gate(def_rd.fn, ev_a.level, ev_b.level);
                end
                n_idx = r_idx + 1'b1;
                if (last) begin
                    if (r_changed || res) begin
                        n_changed = 1'b0;
                        n_state   = S_P_RD;
                    end else begin
                        n_word  = '0;
                        n_flag  = 1'b0;
                        n_state = S_O_RD;
                    end
                end else begin
                    n_changed = r_changed || res;
                    n_state   = S_P_RD;
                end
            end
            S_O_RD: n_state = S_O_ACC;
            S_O_ACC: begin
                if (def_rd.omark) begin
                    if (!ev_a.known) begin
                        n_flag = 1'b1;
                    end else if (ev_a.level && (32'(def_rd.opos) < RESULT_BITS)) begin
                        n_word[def_rd.opos] = 1'b1;
                    end
                end
                n_idx   = r_idx + 1'b1;
                n_state = last ? S_DONE : S_O_RD;
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov              = 1'b1;
                    n_out.result_word = r_word;
                    n_out.unresolved  = r_flag;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_ov      <= 1'b0;
            r_changed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_ov      <= n_ov;
            r_changed <= n_changed;
        end
        r_own  <= n_own;
        r_word <= n_word;
        r_flag <= n_flag;
        r_out  <= n_out;
    end
endmodule
